// ===== src/crcck_pkg.sv =====
// ----------------------------------------------------------------------------
// crcck_pkg: shared types and helpers for the CRC and checksum error checker
// Holds the per-stage word record, the result record and the byte-wide
// CRC and one's-complement arithmetic used by every pipeline stage.
// ----------------------------------------------------------------------------
package crcck_pkg;

  localparam int WORD_BITS  = 64;
  localparam int CHECK_BITS = 8;
  localparam int BYTE_BITS  = 8;

  // Generator low coefficients after reset: x^8 + x^2 + x + 1.
  localparam logic [CHECK_BITS-1:0] GEN_RESET = 8'h07;

  // One word in flight. The message bytes still to be folded sit at the top
  // of data and rx and move up by one byte per stage.
  typedef struct packed {
    logic                  valid;
    logic [WORD_BITS-1:0]  data;
    logic [WORD_BITS-1:0]  rx;
    logic [CHECK_BITS-1:0] crc_d;
    logic [CHECK_BITS-1:0] crc_rx;
    logic [BYTE_BITS-1:0]  sum_d;
    logic [BYTE_BITS-1:0]  sum_rx;
    logic [CHECK_BITS-1:0] ec;
    logic                  nonzero;
  } stage_t;

  typedef struct packed {
    logic [CHECK_BITS-1:0] crc_remainder;
    logic [BYTE_BITS-1:0]  checksum_byte;
    logic                  crc_detects;
    logic                  checksum_detects;
    logic                  pattern_nonzero;
  } result_t;

  // Eight bit-serial CRC steps, most significant message bit first.
  function automatic logic [CHECK_BITS-1:0] crc_byte(
    input logic [CHECK_BITS-1:0] r_in,
    input logic [BYTE_BITS-1:0]  b,
    input logic [CHECK_BITS-1:0] g
  );
    logic [CHECK_BITS-1:0] r;
    logic                  fb;
    r = r_in;
    for (int i = BYTE_BITS - 1; i >= 0; i--) begin
      fb = r[CHECK_BITS-1] ^ b[i];
      r  = {r[CHECK_BITS-2:0], 1'b0} ^ (fb ? g : '0);
    end
    return r;
  endfunction

  // One's-complement byte addition with end-around carry.
  function automatic logic [BYTE_BITS-1:0] oc_add(
    input logic [BYTE_BITS-1:0] a,
    input logic [BYTE_BITS-1:0] b
  );
    logic [BYTE_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[BYTE_BITS-1:0] + {{(BYTE_BITS-1){1'b0}}, s[BYTE_BITS]};
  endfunction

endpackage

// ===== src/crcck_stage.sv =====
// ----------------------------------------------------------------------------
// crcck_stage: one byte of the check pipeline
// Folds the top message byte into both CRC lanes and both checksum lanes,
// then registers the word for the next stage.
// ----------------------------------------------------------------------------
module crcck_stage (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [crcck_pkg::CHECK_BITS-1:0]    gen,
  input  crcck_pkg::stage_t                   in_word,
  output crcck_pkg::stage_t                   out_word
);

  localparam int WB = crcck_pkg::WORD_BITS;
  localparam int BB = crcck_pkg::BYTE_BITS;

  crcck_pkg::stage_t word_next;

  always_comb begin
    word_next        = in_word;
    word_next.data   = {in_word.data[WB-BB-1:0], {BB{1'b0}}};
    word_next.rx     = {in_word.rx[WB-BB-1:0], {BB{1'b0}}};
    word_next.crc_d  = crcck_pkg::crc_byte(in_word.crc_d, in_word.data[WB-1:WB-BB], gen);
    word_next.crc_rx = crcck_pkg::crc_byte(in_word.crc_rx, in_word.rx[WB-1:WB-BB], gen);
    word_next.sum_d  = crcck_pkg::oc_add(in_word.sum_d, in_word.data[WB-1:WB-BB]);
    word_next.sum_rx = crcck_pkg::oc_add(in_word.sum_rx, in_word.rx[WB-1:WB-BB]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_word <= '0;
    end else begin
      out_word <= word_next;
    end
  end

endmodule

// ===== src/crcck_verdict.sv =====
// ----------------------------------------------------------------------------
// crcck_verdict: final recheck and result register
// Forms the transmitted check bytes, rechecks both corrupted codewords and
// registers the result together with its strobe.
// ----------------------------------------------------------------------------
module crcck_verdict (
  input  logic                clk,
  input  logic                rst,
  input  crcck_pkg::stage_t   in_word,
  output logic                done,
  output crcck_pkg::result_t  result
);

  crcck_pkg::result_t             result_next;
  logic [crcck_pkg::BYTE_BITS-1:0] csum;
  logic [crcck_pkg::BYTE_BITS-1:0] total;

  always_comb begin
    csum  = ~in_word.sum_d;
    total = crcck_pkg::oc_add(in_word.sum_rx, csum ^ in_word.ec);
    result_next.crc_remainder    = in_word.crc_d;
    result_next.checksum_byte    = csum;
    // Received remainder is crc(rx data) xor the corrupted check byte.
    result_next.crc_detects      = (in_word.crc_rx ^ in_word.crc_d ^ in_word.ec) != '0;
    result_next.checksum_detects = (~total) != '0;
    result_next.pattern_nonzero  = in_word.nonzero;
  end

  always_ff @(posedge clk) begin
    result <= result_next;
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_word.valid;
    end
  end

endmodule

// ===== src/crc_and_checksum_error_check.sv =====
// ----------------------------------------------------------------------------
// crc_and_checksum_error_check: CRC-8 versus one's-complement checksum check
// Computes the CRC-8 and the inverted one's-complement checksum of a message,
// applies an error pattern to both codewords and reports which check catches
// the corruption.
// ----------------------------------------------------------------------------
// A word is taken whenever start is high and busy is low; busy is high only
// during reset, so a new word may be issued in every clock cycle. Each word
// passes through one pipeline stage per message byte, ceil(DATA_BITS/8)
// stages, followed by one result register that holds its result. The result
// is shown for a single cycle with done high and must be captured then,
// since the receiver has no way to hold it. Results come out in the order
// the words went in. The generator register should only be written while
// no word is in flight.
module crc_and_checksum_error_check #(
  parameter int DATA_BITS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_data,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] data_word,
  input  logic [63:0] error_data_bits,
  input  logic [7:0]  error_check_bits,
  output logic        done,
  output logic [7:0]  crc_remainder,
  output logic [7:0]  checksum_byte,
  output logic        crc_detects,
  output logic        checksum_detects,
  output logic        pattern_nonzero
);

  localparam int WB        = crcck_pkg::WORD_BITS;
  localparam int BB        = crcck_pkg::BYTE_BITS;
  // One stage per byte that holds message bits.
  localparam int NUM_BYTES = (DATA_BITS + BB - 1) / BB;
  // Left shift that brings the first message byte to the top of the word.
  localparam int PAD       = WB - NUM_BYTES * BB;
  localparam logic [WB-1:0] MSG_MASK = {WB{1'b1}} >> (WB - DATA_BITS);

  // Generator coefficients x^7..x^0; the x^8 term is implied.
  logic [crcck_pkg::CHECK_BITS-1:0] gen;

  always_ff @(posedge clk) begin
    if (rst) begin
      gen <= crcck_pkg::GEN_RESET;
    end else if (cfg_we) begin
      gen <= cfg_data;
    end
  end

  // The pipeline never stalls; only reset holds off new words.
  assign busy = rst;

  crcck_pkg::stage_t pipe [NUM_BYTES+1];
  logic [WB-1:0]     data_m;
  logic [WB-1:0]     err_m;

  // Bits above the message width are ignored. Upper zero bytes would add
  // nothing to either sum and leave a zero CRC register unchanged, so only
  // the message bytes are folded.
  always_comb begin
    data_m          = data_word & MSG_MASK;
    err_m           = error_data_bits & MSG_MASK;
    pipe[0].valid   = start && !busy;
    pipe[0].data    = data_m << PAD;
    pipe[0].rx      = (data_m ^ err_m) << PAD;
    pipe[0].crc_d   = '0;
    pipe[0].crc_rx  = '0;
    pipe[0].sum_d   = '0;
    pipe[0].sum_rx  = '0;
    pipe[0].ec      = error_check_bits;
    pipe[0].nonzero = (err_m != '0) || (error_check_bits != '0);
  end

  // Byte stages: each one folds the clean and the received message byte
  // into its CRC lane and its checksum lane.
  for (genvar k = 0; k < NUM_BYTES; k++) begin : g_stage
    crcck_stage u_stage (
      .clk      (clk),
      .rst      (rst),
      .gen      (gen),
      .in_word  (pipe[k]),
      .out_word (pipe[k+1])
    );
  end

  crcck_pkg::result_t result;

  crcck_verdict u_verdict (
    .clk     (clk),
    .rst     (rst),
    .in_word (pipe[NUM_BYTES]),
    .done    (done),
    .result  (result)
  );

  assign crc_remainder    = result.crc_remainder;
  assign checksum_byte    = result.checksum_byte;
  assign crc_detects      = result.crc_detects;
  assign checksum_detects = result.checksum_detects;
  assign pattern_nonzero  = result.pattern_nonzero;

`ifndef SYNTHESIS
  // A clean codeword must pass the CRC recheck.
  a_clean_crc: assert property (@(posedge clk) disable iff (rst)
    done && !pattern_nonzero |-> !crc_detects)
    else $error("CRC flagged a word with no error pattern");

  // A clean codeword must pass the checksum recheck.
  a_clean_csum: assert property (@(posedge clk) disable iff (rst)
    done && !pattern_nonzero |-> !checksum_detects)
    else $error("checksum flagged a word with no error pattern");

  // Every accepted word enters the first byte stage on the next cycle.
  a_enter: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> pipe[1].valid == $past(start && !busy))
    else $error("accepted word lost on entry to the pipeline");
`endif

endmodule
